@@ hw/rtl/dlir_pkg.sv @@
// Shared types and constants for the deduplicating list block.
package dlir_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned ValW            = 16;
  localparam int unsigned CmdW            = 2;
  localparam int unsigned StatusW         = 3;
  localparam int unsigned PosW            = 6;
  localparam int unsigned CountW          = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_DUPLICATE = 3'd2,
    STAT_REMOVED   = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_EMPTY     = 3'd5,
    STAT_LISTED    = 3'd6,
    STAT_UNUSED    = 3'd7
  } status_e;

  // Where the reported position comes from.
  typedef enum logic [1:0] {
    POS_ZERO  = 2'd0,
    POS_RIDX  = 2'd1,
    POS_COUNT = 2'd2,
    POS_HIT   = 2'd3
  } pos_sel_e;

  // Where the reported value comes from.
  typedef enum logic {
    VAL_ECHO  = 1'b0,
    VAL_ENTRY = 1'b1
  } val_sel_e;

  // Controller to datapath.
  typedef struct packed {
    logic     load;
    logic     ptr_clr;
    logic     scan_en;
    logic     hit_save;
    logic     shift_wr;
    logic     append;
    logic     cnt_dec;
    logic     res_en;
    status_e  res_status;
    pos_sel_e pos_sel;
    val_sel_e val_sel;
    logic     res_last;
  } dlir_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic more;
    logic rvalid;
    logic hit;
    logic last_entry;
  } dlir_stat_t;

endpackage

@@ hw/rtl/dedup_list_insert_remove.sv @@
// Top level of the deduplicating list: sequencer plus datapath.
//
// Keeps up to CAPACITY 16-bit values in insertion order with no duplicates.
// Issue a command by raising start while busy is low; the item is taken at
// that clock edge. Insert appends the value unless the list is full or
// already holds it; remove deletes the first match and closes the gap; list
// streams every entry in order, one result per cycle, with last on the final
// one. Every command except the reserved code 3 yields at least one result,
// shown for exactly one cycle with result_valid_o high; there is no way to
// hold results back, so sample them on every strobe. entry_count_o is the
// count after the command. Timing is set by the single read port of the
// entry memory, which visits one entry per cycle. Full and empty cases are
// answered from the count with no scan; an insert or a remove scans the
// entries in order, and an insert stops early on a duplicate; a successful
// remove then moves each later entry down one place, and a list shows its
// entries in order as they are read. busy drops in the cycle the final
// result is shown, so the next command can be taken at the end of that
// cycle.
module dedup_list_insert_remove #(
  parameter int unsigned CAPACITY = dlir_pkg::DefaultCapacity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [dlir_pkg::CmdW-1:0]    command_i,
  input  logic [dlir_pkg::ValW-1:0]    item_value_i,
  output logic                         result_valid_o,
  output logic [dlir_pkg::StatusW-1:0] status_o,
  output logic [dlir_pkg::ValW-1:0]    entry_value_o,
  output logic [dlir_pkg::PosW-1:0]    entry_position_o,
  output logic [dlir_pkg::CountW-1:0]  entry_count_o,
  output logic                         last_o
);
  import dlir_pkg::*;

  dlir_cmd_t  cmd;
  dlir_stat_t stat;

  // Sequencer: decode the command and step through scan, shift or list.
  dlir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .stat_i    (stat),
    .busy_o    (busy),
    .cmd_o     (cmd)
  );

  // Datapath: entry memory, pointer, count and the result register.
  dlir_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_value_i     (item_value_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .entry_value_o    (entry_value_o),
    .entry_position_o (entry_position_o),
    .entry_count_o    (entry_count_o),
    .last_o           (last_o)
  );

endmodule

@@ hw/rtl/dlir_ctrl.sv @@
// Command sequencer for the deduplicating list block.
module dlir_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [1:0]              command_i,
  input  dlir_pkg::dlir_stat_t    stat_i,
  output logic                    busy_o,
  output dlir_pkg::dlir_cmd_t     cmd_o
);
  import dlir_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SCAN     = 5'b00100,
    S_SHIFT    = 5'b01000,
    S_LIST     = 5'b10000
  } state_e;

  state_e state_q, state_d;
  cmd_e   op_q, op_d;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.ptr_clr = 1'b1;
          op_d          = cmd_e'(command_i);
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_q)
          CMD_INSERT: begin
            if (stat_i.full) begin
              cmd_o.res_en     = 1'b1;
              cmd_o.res_status = STAT_FULL;
              cmd_o.res_last   = 1'b1;
              state_d          = S_IDLE;
            end else begin
              state_d = S_SCAN;
            end
          end
          CMD_REMOVE: begin
            if (stat_i.empty) begin
              cmd_o.res_en     = 1'b1;
              cmd_o.res_status = STAT_EMPTY;
              cmd_o.res_last   = 1'b1;
              state_d          = S_IDLE;
            end else begin
              state_d = S_SCAN;
            end
          end
          CMD_LIST: begin
            if (stat_i.empty) begin
              cmd_o.res_en     = 1'b1;
              cmd_o.res_status = STAT_EMPTY;
              cmd_o.res_last   = 1'b1;
              state_d          = S_IDLE;
            end else begin
              state_d = S_LIST;
            end
          end
          default: begin
            // Drop the reserved command silently.
            state_d = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.hit) begin
          if (op_q == CMD_INSERT) begin
            cmd_o.res_en     = 1'b1;
            cmd_o.res_status = STAT_DUPLICATE;
            cmd_o.pos_sel    = POS_RIDX;
            cmd_o.res_last   = 1'b1;
            state_d          = S_IDLE;
          end else begin
            cmd_o.hit_save = 1'b1;
            state_d        = S_SHIFT;
          end
        end else if (!stat_i.rvalid && !stat_i.more) begin
          cmd_o.res_en   = 1'b1;
          cmd_o.res_last = 1'b1;
          state_d        = S_IDLE;
          if (op_q == CMD_INSERT) begin
            cmd_o.append     = 1'b1;
            cmd_o.res_status = STAT_INSERTED;
            cmd_o.pos_sel    = POS_COUNT;
          end else begin
            cmd_o.res_status = STAT_NOT_FOUND;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.scan_en  = 1'b1;
        cmd_o.shift_wr = 1'b1;
        if (!stat_i.rvalid && !stat_i.more) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = STAT_REMOVED;
          cmd_o.pos_sel    = POS_HIT;
          cmd_o.res_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_LIST: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.rvalid) begin
          cmd_o.res_en     = 1'b1;
          cmd_o.res_status = STAT_LISTED;
          cmd_o.pos_sel    = POS_RIDX;
          cmd_o.val_sel    = VAL_ENTRY;
          cmd_o.res_last   = stat_i.last_entry;
          if (stat_i.last_entry) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= CMD_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

@@ hw/rtl/dlir_dpath.sv @@
// Entry store, scan pointer, count and result registers.
module dlir_dpath #(
  parameter int unsigned CAPACITY = dlir_pkg::DefaultCapacity
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [dlir_pkg::ValW-1:0]        item_value_i,
  input  dlir_pkg::dlir_cmd_t              cmd_i,
  output dlir_pkg::dlir_stat_t             stat_o,
  output logic                             result_valid_o,
  output logic [dlir_pkg::StatusW-1:0]     status_o,
  output logic [dlir_pkg::ValW-1:0]        entry_value_o,
  output logic [dlir_pkg::PosW-1:0]        entry_position_o,
  output logic [dlir_pkg::CountW-1:0]      entry_count_o,
  output logic                             last_o
);
  import dlir_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [ValW-1:0] mem_q [CAPACITY];

  logic [CntW-1:0] count_q, ptr_q;
  logic            rvalid_q;
  logic [ValW-1:0] rdata_q, val_q;
  logic [IdxW-1:0] ridx_q, hit_q;

  logic            res_valid_q, res_last_q;
  logic [StatusW-1:0] res_status_q;
  logic [ValW-1:0] res_value_q;
  logic [IdxW-1:0] res_pos_q;

  logic            rd_go, wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [ValW-1:0] wr_data;
  logic [IdxW-1:0] pos_mux;

  assign stat_o.full       = (count_q == CntW'(CAPACITY));
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.more       = (ptr_q < count_q);
  assign stat_o.rvalid     = rvalid_q;
  assign stat_o.hit        = rvalid_q && (rdata_q == val_q);
  assign stat_o.last_entry = ((CntW'(ridx_q) + CntW'(1)) == count_q);

  assign rd_go = cmd_i.scan_en && stat_o.more;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IdxW-1:0];
    wr_data = val_q;
    if (cmd_i.append) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift_wr && rvalid_q) begin
      // Move the entry just read one place down.
      wr_en   = 1'b1;
      wr_addr = ridx_q - IdxW'(1);
      wr_data = rdata_q;
    end
  end

  always_comb begin
    case (cmd_i.pos_sel)
      POS_RIDX:  pos_mux = ridx_q;
      POS_COUNT: pos_mux = count_q[IdxW-1:0];
      POS_HIT:   pos_mux = hit_q;
      default:   pos_mux = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      rdata_q <= mem_q[ptr_q[IdxW-1:0]];
      ridx_q  <= ptr_q[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= item_value_i;
    end
    if (cmd_i.hit_save) begin
      hit_q <= ridx_q;
    end
    if (cmd_i.res_en) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= (cmd_i.val_sel == VAL_ENTRY) ? rdata_q : val_q;
      res_pos_q    <= pos_mux;
      res_last_q   <= cmd_i.res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      rvalid_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      rvalid_q    <= rd_go;
      res_valid_q <= cmd_i.res_en;
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (rd_go) begin
        ptr_q <= ptr_q + CntW'(1);
      end
      if (cmd_i.append) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assign result_valid_o   = res_valid_q;
  assign status_o         = res_status_q;
  assign entry_value_o    = res_value_q;
  assign entry_position_o = PosW'(res_pos_q);
  assign entry_count_o    = CountW'(count_q);
  assign last_o           = res_last_q;

endmodule

@@ hw/rtl/dlir_chk.sv @@
// Port-level checks for the deduplicating list, bound to the top level.
module dlir_chk #(
  parameter int unsigned CAPACITY = dlir_pkg::DefaultCapacity
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         result_valid_o,
  input logic [dlir_pkg::StatusW-1:0] status_o,
  input logic [dlir_pkg::PosW-1:0]    entry_position_o,
  input logic [dlir_pkg::CountW-1:0]  entry_count_o,
  input logic                         last_o
);
  import dlir_pkg::*;

  // A taken command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after a command was taken");

  // A list stream is unbroken until its final entry.
  a_list_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o && (status_o == STAT_LISTED))
    else $error("list stream broken before last entry");

  // The final listed entry sits at position count minus one.
  a_list_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o && (status_o == STAT_LISTED) |->
      (CountW'(entry_position_o) + CountW'(1)) == entry_count_o)
    else $error("last listed entry not at end of list");

  // Full is reported only at capacity, with position zero.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == STAT_FULL) |->
      (entry_count_o == CountW'(CAPACITY)) && (entry_position_o == '0))
    else $error("full reported below capacity");

endmodule

bind dedup_list_insert_remove dlir_chk #(
  .CAPACITY (CAPACITY)
) u_dlir_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .result_valid_o   (result_valid_o),
  .status_o         (status_o),
  .entry_position_o (entry_position_o),
  .entry_count_o    (entry_count_o),
  .last_o           (last_o)
);

@@ dv/dedup_list_insert_remove_tb.sv @@
// Testbench for the deduplicating list: directed and random command items checked against a scoreboard.
module dedup_list_insert_remove_tb;
  import dlir_pkg::*;

  localparam int unsigned Cap      = DefaultCapacity;
  localparam int unsigned NumDir   = 21;
  localparam int unsigned NumRand  = 260;
  localparam int unsigned MaxPrint = 40;

  typedef struct {
    status_e             status;
    logic [ValW-1:0]     value;
    logic [PosW-1:0]     pos;
    logic [CountW-1:0]   count;
    logic                last;
  } list_result_t;

  // Shadow copy of the list; predicts the results of each accepted item.
  class list_scoreboard;
    logic [ValW-1:0] stored[Cap];
    int unsigned     n_stored;
    list_result_t    pending_results[$];
    int unsigned     errors;

    function int find_value(logic [ValW-1:0] value);
      for (int i = 0; i < n_stored; i++) begin
        if (stored[i] == value) return i;
      end
      return -1;
    endfunction

    // Note an accepted item and queue the results it must cause.
    function void take_command(cmd_e cmd, logic [ValW-1:0] value);
      list_result_t r;
      int           hit_idx;
      r.value  = value;
      r.pos    = '0;
      r.last   = 1'b1;
      r.status = STAT_EMPTY;
      case (cmd)
        CMD_INSERT: begin
          // Full wins over duplicate.
          if (n_stored >= Cap) begin
            r.status = STAT_FULL;
          end else begin
            hit_idx = find_value(value);
            if (hit_idx >= 0) begin
              r.status = STAT_DUPLICATE;
              r.pos    = hit_idx[PosW-1:0];
            end else begin
              stored[n_stored] = value;
              r.status = STAT_INSERTED;
              r.pos    = n_stored[PosW-1:0];
              n_stored++;
            end
          end
          r.count = n_stored[CountW-1:0];
          pending_results.push_back(r);
        end
        CMD_REMOVE: begin
          if (n_stored != 0) begin
            hit_idx = find_value(value);
            if (hit_idx >= 0) begin
              // Close the gap left by the removed entry.
              for (int j = hit_idx; j + 1 < n_stored; j++) stored[j] = stored[j+1];
              n_stored--;
              r.status = STAT_REMOVED;
              r.pos    = hit_idx[PosW-1:0];
            end else begin
              r.status = STAT_NOT_FOUND;
            end
          end
          r.count = n_stored[CountW-1:0];
          pending_results.push_back(r);
        end
        CMD_LIST: begin
          r.count = n_stored[CountW-1:0];
          if (n_stored == 0) begin
            pending_results.push_back(r);
          end else begin
            for (int i = 0; i < n_stored; i++) begin
              r.status = STAT_LISTED;
              r.value  = stored[i];
              r.pos    = i[PosW-1:0];
              r.last   = (i + 1 == n_stored);
              pending_results.push_back(r);
            end
          end
        end
        default: ;  // reserved code: no result, no change
      endcase
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MaxPrint) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    // Compare one strobed result with the oldest expectation.
    function void check_result(logic [StatusW-1:0] status, logic [ValW-1:0] value,
                               logic [PosW-1:0] pos, logic [CountW-1:0] count,
                               logic last);
      list_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxPrint) begin
          $display("%0t: unexpected result, expected none, actual status %0h value %0h",
                   $time, status, value);
        end
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) report("status", want.status, status);
      if (value !== want.value) report("entry_value", want.value, value);
      if (pos !== want.pos) report("entry_position", want.pos, pos);
      if (count !== want.count) report("entry_count", want.count, count);
      if (last !== want.last) report("last", want.last, last);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CmdW-1:0]     command_i;
  logic [ValW-1:0]     item_value_i;
  logic                result_valid_o;
  logic [StatusW-1:0]  status_o;
  logic [ValW-1:0]     entry_value_o;
  logic [PosW-1:0]     entry_position_o;
  logic [CountW-1:0]   entry_count_o;
  logic                last_o;

  list_scoreboard sb = new();
  int unsigned    burst_left;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  dedup_list_insert_remove #(
    .CAPACITY(Cap)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .item_value_i    (item_value_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .entry_value_o   (entry_value_o),
    .entry_position_o(entry_position_o),
    .entry_count_o   (entry_count_o),
    .last_o          (last_o)
  );

  // Results cannot be held off: take every strobe.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      sb.check_result(status_o, entry_value_o, entry_position_o, entry_count_o, last_o);
    end
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int unsigned next_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Pick a stored value with the given odds, else an edge value or noise.
  function automatic logic [ValW-1:0] pick_value(int unsigned stored_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sb.n_stored != 0 && r < stored_pct) return sb.stored[$urandom_range(0, sb.n_stored - 1)];
    if (r < stored_pct + 15) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return 16'h8000;
        default: return ValW'($urandom_range(0, 7));
      endcase
    end
    return ValW'($urandom_range(0, 16'hFFFF));
  endfunction

  // Hold start until the item is taken; the gap drops start first.
  task automatic issue(cmd_e cmd, logic [ValW-1:0] value, int unsigned gap);
    if (gap != 0) begin
      start        <= 1'b0;
      command_i    <= CmdW'($urandom_range(0, 3));
      item_value_i <= ValW'($urandom_range(0, 16'hFFFF));
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    command_i    <= cmd;
    item_value_i <= value;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.take_command(cmd, value);
  endtask

  initial begin
    cmd_e            dir_cmd[NumDir];
    logic [ValW-1:0] dir_val[NumDir];
    cmd_e            cmd;
    bit              filling;
    int unsigned     r;
    int unsigned     spins;

    // Empty cases, extremes, duplicates, shift on remove, the reserved code.
    dir_cmd = '{CMD_LIST,   CMD_REMOVE, CMD_INSERT, CMD_INSERT, CMD_INSERT, CMD_INSERT,
                CMD_INSERT, CMD_LIST,   CMD_REMOVE, CMD_RSVD,   CMD_REMOVE, CMD_LIST,
                CMD_REMOVE, CMD_REMOVE, CMD_LIST,   CMD_INSERT, CMD_INSERT, CMD_RSVD,
                CMD_LIST,   CMD_REMOVE, CMD_REMOVE};
    dir_val = '{16'h1234, 16'hBEEF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                16'h8000, 16'h0000, 16'h0007, 16'hAAAA, 16'h0000, 16'hFFFF,
                16'h8000, 16'hFFFF, 16'h5A5A, 16'h5555, 16'hAAAA, 16'h5555,
                16'h0000, 16'hAAAA, 16'h5555};

    burst_left   = 0;
    filling      = 1'b1;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    command_i    <= CMD_INSERT;
    item_value_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDir; i++) issue(dir_cmd[i], dir_val[i], next_gap());

    // Sweep the fill level up to full and back down to empty.
    for (int i = 0; i < NumRand; i++) begin
      if (sb.n_stored == 0) filling = 1'b1;
      else if (sb.n_stored == Cap && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if ($urandom_range(0, 59) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (filling) begin
        cmd = (r < 75) ? CMD_INSERT : (r < 85) ? CMD_REMOVE : (r < 96) ? CMD_LIST : CMD_RSVD;
      end else begin
        cmd = (r < 15) ? CMD_INSERT : (r < 80) ? CMD_REMOVE : (r < 96) ? CMD_LIST : CMD_RSVD;
      end
      issue(cmd, pick_value((cmd == CMD_REMOVE) ? 75 : 15), next_gap());
    end
    start <= 1'b0;

    spins = 0;
    while (sb.pending_results.size() != 0 && spins < 100000) begin
      @(posedge clk_i);
      spins++;
    end
    // Drain: catch any stray result after the last one expected.
    repeat (200) @(posedge clk_i);

    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d results still expected, none arrived", $time,
               sb.pending_results.size());
    end
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("dedup_list_insert_remove_tb OK");
    end else begin
      $display("dedup_list_insert_remove_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("dedup_list_insert_remove_tb NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/dlir_pkg.sv
hw/rtl/dlir_ctrl.sv
hw/rtl/dlir_dpath.sv
hw/rtl/dedup_list_insert_remove.sv
hw/rtl/dlir_chk.sv
dv/dedup_list_insert_remove_tb.sv
